### rtl/rpab_pkg.sv
package rpab_pkg;

    localparam int unsigned PIX_W     = 16;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ALPHA_W   = 8;
    localparam int unsigned WEIGHT_W  = 5;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 16;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_KEY   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEVEL = 8'd1;

    localparam logic [ALPHA_W-1:0]  ALPHA_RESET = 8'd16;
    localparam logic [ALPHA_W-1:0]  ALPHA_MAX   = 8'd31;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN  = 5'd1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX  = 5'd31;

    // one classified pixel pair on its way from front to back
    typedef struct packed {
        logic [WORD_W-1:0]   sprite;
        logic [WORD_W-1:0]   background;
        logic [1:0]          keyed;     // bit 1 upper pixel, bit 0 lower pixel
        logic [WEIGHT_W-1:0] weight;    // clamped background weight
    } t_work;

endpackage

### rtl/rpab_front.sv
module rpab_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [rpab_pkg::WORD_W-1:0]    i_sprite_word,
    input  logic [rpab_pkg::WORD_W-1:0]    i_background_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rpab_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rpab_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                           i_q_full,
    output logic                           o_q_wr_en,
    output rpab_pkg::t_work                o_q_wr_data
);
    import rpab_pkg::*;

    logic [PIX_W-1:0]    r_color_key;
    logic [ALPHA_W-1:0]  r_alpha_level;
    logic [WEIGHT_W-1:0] weight;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_key   <= '0;
            r_alpha_level <= ALPHA_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_COLOR_KEY) begin
                r_color_key <= i_cfg_data;
            end else if (i_cfg_index == CFG_ALPHA_LEVEL) begin
                r_alpha_level <= i_cfg_data[ALPHA_W-1:0];
            end
        end
    end

    // clamp weight to 1..31
    always_comb begin
        priority if (r_alpha_level == '0) begin
            weight = WEIGHT_MIN;
        end else if (r_alpha_level > ALPHA_MAX) begin
            weight = WEIGHT_MAX;
        end else begin
            weight = r_alpha_level[WEIGHT_W-1:0];
        end
    end

    assign full      = i_q_full;
    assign o_q_wr_en = push && !i_q_full;

    always_comb begin
        o_q_wr_data.sprite     = i_sprite_word;
        o_q_wr_data.background = i_background_word;
        o_q_wr_data.keyed[1]   = (i_sprite_word[WORD_W-1:PIX_W] == r_color_key);
        o_q_wr_data.keyed[0]   = (i_sprite_word[PIX_W-1:0] == r_color_key);
        o_q_wr_data.weight     = weight;
    end

endmodule

### rtl/rpab_queue.sv
module rpab_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  rpab_pkg::t_work i_wr_data,
    output logic            o_full,
    input  logic            i_rd_en,
    output rpab_pkg::t_work o_rd_data,
    output logic            o_empty
);
    import rpab_pkg::*;

    t_work      r_mem [4];
    logic [1:0] r_wptr, n_wptr;
    logic [1:0] r_rptr, n_rptr;
    logic [2:0] r_count, n_count;

    assign o_full    = (r_count == 3'd4);
    assign o_empty   = (r_count == 3'd0);
    assign o_rd_data = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr + 2'(i_wr_en);
        n_rptr  = r_rptr + 2'(i_rd_en);
        n_count = r_count + 3'(i_wr_en) - 3'(i_rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

endmodule

### rtl/rpab_back.sv
module rpab_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rpab_pkg::t_work             i_q_rd_data,
    input  logic                        i_q_empty,
    output logic                        o_q_rd_en,
    output logic                        empty,
    input  logic                        pop,
    output logic [rpab_pkg::WORD_W-1:0] o_blended_word
);
    import rpab_pkg::*;

    function automatic logic [4:0] blend5(logic [4:0] s, logic [4:0] b, logic [4:0] a);
        logic [5:0] ws;
        logic [9:0] ps;
        logic [9:0] pb;
        logic [5:0] sum;
        ws  = 6'd32 - {1'b0, a};
        ps  = 10'({5'b0, s} * {4'b0, ws});
        pb  = 10'({5'b0, b} * {5'b0, a});
        sum = {1'b0, ps[9:5]} + {1'b0, pb[9:5]};
        return sum[4:0];
    endfunction

    function automatic logic [5:0] blend6(logic [5:0] s, logic [5:0] b, logic [4:0] a);
        logic [5:0]  ws;
        logic [10:0] ps;
        logic [10:0] pb;
        logic [6:0]  sum;
        ws  = 6'd32 - {1'b0, a};
        ps  = 11'({5'b0, s} * {5'b0, ws});
        pb  = 11'({5'b0, b} * {6'b0, a});
        sum = {1'b0, ps[10:5]} + {1'b0, pb[10:5]};
        return sum[5:0];
    endfunction

    function automatic logic [15:0] blend_pixel(logic [15:0] s, logic [15:0] b,
                                                logic [4:0] a);
        return {blend5(s[15:11], b[15:11], a),
                blend6(s[10:5], b[10:5], a),
                blend5(s[4:0], b[4:0], a)};
    endfunction

    logic [WORD_W-1:0] result;
    logic [WORD_W-1:0] r_out [2];
    logic              r_wptr, r_rptr;
    logic [1:0]        r_count, n_count;
    logic              out_wr, out_rd;

    // keyed halves carry the sprite pixel, which equals the key
    always_comb begin
        result[WORD_W-1:PIX_W] = i_q_rd_data.keyed[1]
            ? i_q_rd_data.sprite[WORD_W-1:PIX_W]
            : blend_pixel(i_q_rd_data.sprite[WORD_W-1:PIX_W],
                          i_q_rd_data.background[WORD_W-1:PIX_W], i_q_rd_data.weight);
        result[PIX_W-1:0] = i_q_rd_data.keyed[0]
            ? i_q_rd_data.sprite[PIX_W-1:0]
            : blend_pixel(i_q_rd_data.sprite[PIX_W-1:0],
                          i_q_rd_data.background[PIX_W-1:0], i_q_rd_data.weight);
    end

    assign out_wr         = !i_q_empty && (r_count != 2'd2);
    assign out_rd         = pop && !empty;
    assign o_q_rd_en      = out_wr;
    assign empty          = (r_count == 2'd0);
    assign o_blended_word = r_out[r_rptr];
    assign n_count        = r_count + 2'(out_wr) - 2'(out_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr ^ out_wr;
            r_rptr  <= r_rptr ^ out_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_wr) begin
            r_out[r_wptr] <= result;
        end
    end

endmodule

### rtl/rgb565_pair_alpha_blend_keyed_unit.sv
// rgb565 pixel-pair alpha blend with color key
//
// input channel: push / full with i_sprite_word and i_background_word, each
//   two rgb565 pixels (upper pixel in bits 31:16); a request is taken when
//   push is high and full is low
// result channel: empty / pop with o_blended_word; the oldest result sits on
//   o_blended_word while empty is low and leaves when pop is high
// config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index 0
//   writes the color key, 1 writes the alpha level; other indexes are ignored
// path: an accepted request is written into the middle queue, then blended
//   into the result buffer, from where it shows on the result side
// throughput: one request per cycle while the result side drains, set by the
//   single blend stage in the back end which finishes a word each cycle
// reset (synchronous, active low): both queues empty, key 0, alpha 16
// stall: when pop is held low the two-entry result buffer and the four-entry
//   middle queue fill up, then full rises; nothing is dropped
module rgb565_pair_alpha_blend_keyed_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [rpab_pkg::WORD_W-1:0]    i_sprite_word,
    input  logic [rpab_pkg::WORD_W-1:0]    i_background_word,
    output logic                           empty,
    input  logic                           pop,
    output logic [rpab_pkg::WORD_W-1:0]    o_blended_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rpab_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rpab_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import rpab_pkg::*;

    // front to queue
    logic  q_wr_en;
    t_work q_wr_data;
    logic  q_full;
    // queue to back
    logic  q_rd_en;
    t_work q_rd_data;
    logic  q_empty;

    // front: config registers, key match per half, weight clamp
    rpab_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_sprite_word     (i_sprite_word),
        .i_background_word (i_background_word),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_q_full          (q_full),
        .o_q_wr_en         (q_wr_en),
        .o_q_wr_data       (q_wr_data)
    );

    // decoupling queue between classification and blend
    rpab_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (q_wr_en),
        .i_wr_data (q_wr_data),
        .o_full    (q_full),
        .i_rd_en   (q_rd_en),
        .o_rd_data (q_rd_data),
        .o_empty   (q_empty)
    );

    // back: per-channel blend into a small result buffer
    rpab_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_rd_data    (q_rd_data),
        .i_q_empty      (q_empty),
        .o_q_rd_en      (q_rd_en),
        .empty          (empty),
        .pop            (pop),
        .o_blended_word (o_blended_word)
    );

endmodule
